// ===== rtl/binary_max_heap_defines.svh =====
// Assertion macros used by binary_max_heap.sv.
`ifndef BINARY_MAX_HEAP_DEFINES_SVH
`define BINARY_MAX_HEAP_DEFINES_SVH

`ifndef SYNTHESIS

`define BMH_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

`define BMH_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`else

`define BMH_ASSERT(lbl, clk, rst, prop, msg)

`define BMH_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== rtl/bmh_pkg.sv =====
`default_nettype none

package bmh_pkg;

  localparam int VALUE_W      = 32;
  localparam int COUNT_W      = 7;
  localparam int STATUS_W     = 2;
  localparam int DEF_CAPACITY = 64;

  localparam logic FN_PUSH = 1'b0;
  localparam logic FN_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_PUSH_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_UP,
    S_UP_CMP,
    S_LAST,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_DN_CMP,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/bmh_ram.sv =====
`default_nettype none

module bmh_ram
  import bmh_pkg::*;
#(
  parameter int DEPTH = DEF_CAPACITY,
  parameter int AW    = $clog2(DEF_CAPACITY)
) (
  input  wire logic               clk,
  input  wire logic               we,
  input  wire logic [AW-1:0]      waddr,
  input  wire logic [VALUE_W-1:0] wdata,
  input  wire logic [AW-1:0]      raddr,
  output logic      [VALUE_W-1:0] rdata
);

  logic [VALUE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/binary_max_heap.sv =====
// Binary max-heap priority queue of signed 32-bit words.
// Input channel (in_valid/in_ready): func 0 pushes value, func 1 pops the maximum.
// Output channel (out_valid/out_ready): one result word per input word, carrying
// the popped value, the new maximum, the entry count and a status code.
// One word is worked on at a time; in_ready is high only while the sequencer idles.
// Every heap access goes through one single-port-write, registered-read RAM and
// one shared signed comparator, so the sift cost is set by that RAM port.
// Push: the word climbs from the new leaf, reading each parent and moving it down
//   while the word is strictly larger, then is written where it stops.
// Pop: the last entry is fetched and sifted down from the root, reading the left
//   and, if present, the right child and moving the larger child up while it
//   beats the entry; popping the sole entry skips the sift.
// A refused push or pop goes straight to the result.
// The next word can be accepted in the cycle after its result is loaded.
// The result sits in an output register, so the next word is accepted while a
// result still waits; if the receiver stalls, the following result holds in the
// sequencer until the output register frees up.
// Reset clears the entry count and the output valid; RAM contents are left as is.
`default_nettype none

`include "binary_max_heap_defines.svh"

module binary_max_heap
  import bmh_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic                       func,
  input  wire logic signed [VALUE_W-1:0]  value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic signed [VALUE_W-1:0]       popped_value,
  output logic signed [VALUE_W-1:0]       top_value,
  output logic        [COUNT_W-1:0]       entry_count,
  output logic        [STATUS_W-1:0]      status
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int EW = AW + 2;

  state_t state, state_next;

  logic [CW-1:0]      count, count_next;
  logic [AW-1:0]      idx, idx_next;
  logic [AW-1:0]      ci, ci_next;
  logic [VALUE_W-1:0] x, x_next;
  logic [VALUE_W-1:0] cv, cv_next;
  logic [VALUE_W-1:0] pop_val, pop_val_next;
  logic [STATUS_W-1:0] st, st_next;
  logic [VALUE_W-1:0] root;
  logic               load_out;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [VALUE_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [VALUE_W-1:0] rd_data;

  logic [VALUE_W-1:0] cmp_a, cmp_b;
  logic               cmp_gt;

  logic [EW-1:0]      ch_l, ch_r, count_ext;
  logic [AW-1:0]      parent;
  logic [CW-1:0]      cnt_m1;
  logic [CW+COUNT_W-1:0] cnt_wide;

  bmh_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  // Shared signed comparator.
  assign cmp_gt = $signed(cmp_a) > $signed(cmp_b);

  assign ch_l      = {1'b0, idx, 1'b1};
  assign ch_r      = ch_l + EW'(1);
  assign count_ext = EW'(count);
  assign parent    = (idx - AW'(1)) >> 1;
  assign cnt_m1    = count - CW'(1);
  assign cnt_wide  = {{COUNT_W{1'b0}}, count};

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx     <= idx_next;
    ci      <= ci_next;
    x       <= x_next;
    cv      <= cv_next;
    pop_val <= pop_val_next;
    st      <= st_next;
    // Shadow of the root entry for the top_value field.
    if (mem_we && mem_waddr == '0) begin
      root <= mem_wdata;
    end
    if (load_out) begin
      popped_value <= pop_val;
      top_value    <= (count == '0) ? '0 : root;
      entry_count  <= cnt_wide[COUNT_W-1:0];
      status       <= st;
    end
  end

  always_comb begin
    state_next   = state;
    count_next   = count;
    idx_next     = idx;
    ci_next      = ci;
    x_next       = x;
    cv_next      = cv;
    pop_val_next = pop_val;
    st_next      = st;
    mem_we       = 1'b0;
    mem_waddr    = idx;
    mem_wdata    = x;
    mem_raddr    = '0;
    cmp_a        = x;
    cmp_b        = rd_data;
    load_out     = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          st_next      = ST_OK;
          pop_val_next = '0;
          x_next       = value;
          if (func == FN_PUSH) begin
            if (count == CW'(CAPACITY)) begin
              st_next    = ST_PUSH_FULL;
              state_next = S_DONE;
            end else begin
              idx_next   = count[AW-1:0];
              state_next = S_UP;
            end
          end else begin
            if (count == '0) begin
              st_next    = ST_POP_EMPTY;
              state_next = S_DONE;
            end else begin
              // Fetch the last entry and shrink the heap.
              pop_val_next = root;
              mem_raddr    = cnt_m1[AW-1:0];
              count_next   = cnt_m1;
              state_next   = S_LAST;
            end
          end
        end
      end

      S_UP: begin
        if (idx == '0) begin
          mem_we     = 1'b1;
          mem_waddr  = '0;
          mem_wdata  = x;
          count_next = count + CW'(1);
          state_next = S_DONE;
        end else begin
          mem_raddr  = parent;
          ci_next    = parent;
          state_next = S_UP_CMP;
        end
      end

      S_UP_CMP: begin
        cmp_a  = x;
        cmp_b  = rd_data;
        mem_we = 1'b1;
        if (cmp_gt) begin
          // Move the parent down one level and keep climbing.
          mem_wdata  = rd_data;
          idx_next   = ci;
          state_next = S_UP;
        end else begin
          mem_wdata  = x;
          count_next = count + CW'(1);
          state_next = S_DONE;
        end
      end

      S_LAST: begin
        x_next = rd_data;
        if (count == '0) begin
          state_next = S_DONE;
        end else begin
          idx_next   = '0;
          state_next = S_DN;
        end
      end

      S_DN: begin
        if (ch_l >= count_ext) begin
          mem_we     = 1'b1;
          mem_wdata  = x;
          state_next = S_DONE;
        end else begin
          mem_raddr  = ch_l[AW-1:0];
          ci_next    = ch_l[AW-1:0];
          state_next = S_DN_L;
        end
      end

      S_DN_L: begin
        cv_next = rd_data;
        if (ch_r < count_ext) begin
          mem_raddr  = ch_r[AW-1:0];
          state_next = S_DN_R;
        end else begin
          state_next = S_DN_CMP;
        end
      end

      S_DN_R: begin
        // Right child wins only when strictly larger.
        cmp_a = rd_data;
        cmp_b = cv;
        if (cmp_gt) begin
          cv_next = rd_data;
          ci_next = ci + AW'(1);
        end
        state_next = S_DN_CMP;
      end

      S_DN_CMP: begin
        cmp_a  = cv;
        cmp_b  = x;
        mem_we = 1'b1;
        if (cmp_gt) begin
          mem_wdata  = cv;
          idx_next   = ci;
          state_next = S_DN;
        end else begin
          mem_wdata  = x;
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `BMH_ASSERT(a_count_bound, clk, rst, count <= CW'(CAPACITY), "entry count above capacity")
  `BMH_ASSERT_IMP(a_accept_busy, clk, rst, in_valid && in_ready, ##1 (state != S_IDLE),
                  "accepted word did not start the sequencer")
  `BMH_ASSERT_IMP(a_we_busy, clk, rst, mem_we, state != S_IDLE, "heap write while idle")
  `BMH_ASSERT_IMP(a_empty_pop, clk, rst, load_out && st == ST_POP_EMPTY, count == '0,
                  "refused pop with entries present")
  `BMH_ASSERT_IMP(a_count_step, clk, rst, state == S_DONE && $past(state) == S_IDLE,
                  $stable(count), "refused operation changed the entry count")

endmodule

`default_nettype wire
